### sv/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the line segment clipper
// Coordinate and parameter widths, transfer structs and pipeline payloads.
// ----------------------------------------------------------------------------
`default_nettype none
package lsc_pkg;
  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int DIFF_W          = COORD_BITS + 1;
  localparam int PROD_W          = PARAM_FRAC_BITS + 1 + COORD_BITS;

  localparam logic [PARAM_FRAC_BITS:0] P_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
  localparam logic [PROD_W:0] P_HALF = (PROD_W + 1)'(1) << (PARAM_FRAC_BITS - 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [PARAM_FRAC_BITS:0]     param_t;
  typedef logic [PROD_W-1:0]            prod_t;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   visible;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
  } out_item_t;

  // one window edge while its ratio is being worked out
  typedef struct packed {
    logic   rej;
    logic   ent;
    logic   ext;
    logic   div;
    mag_t   d;
    mag_t   rem;
    param_t quo;
  } edge_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    logic   negx;
    logic   negy;
    mag_t   adx;
    mag_t   ady;
  } seg_t;

  typedef struct packed {
    seg_t        seg;
    edge_t [3:0] e;
  } pipe_t;

  typedef struct packed {
    logic   ok;
    seg_t   seg;
    param_t u1;
    param_t u2;
  } comb_t;

  typedef struct packed {
    logic  ok;
    seg_t  seg;
    prod_t px1;
    prod_t py1;
    prod_t px2;
    prod_t py2;
  } mul_t;
endpackage
`default_nettype wire

### sv/lsc_div_cell.sv
// ----------------------------------------------------------------------------
// lsc_div_cell: one quotient bit of the edge ratios
// Restoring division on the ratio of every edge that divides, registered toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  lsc_pkg::pipe_t up_data,
  output logic          up_ready,
  output logic          dn_valid,
  output lsc_pkg::pipe_t dn_data,
  input  logic          dn_ready
);
  import lsc_pkg::*;

  logic  valid_r;
  pipe_t data_r;
  pipe_t data_nxt;
  logic [COORD_BITS:0] r2 [4];

  always_comb begin
    data_nxt = up_data;
    for (int i = 0; i < 4; i++) begin
      r2[i] = {up_data.e[i].rem, 1'b0};
      if (up_data.e[i].div) begin
        if (r2[i] >= {1'b0, up_data.e[i].d}) begin
          data_nxt.e[i].rem = COORD_BITS'(r2[i] - {1'b0, up_data.e[i].d});
          data_nxt.e[i].quo = {up_data.e[i].quo[PARAM_FRAC_BITS-1:0], 1'b1};
        end else begin
          data_nxt.e[i].rem = r2[i][COORD_BITS-1:0];
          data_nxt.e[i].quo = {up_data.e[i].quo[PARAM_FRAC_BITS-1:0], 1'b0};
        end
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
endmodule
`default_nettype wire

### sv/lsc_lerp.sv
// ----------------------------------------------------------------------------
// lsc_lerp: parameter combine and endpoint interpolation
// Entry/exit selection, four multiplies, then rounding into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_lerp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  lsc_pkg::pipe_t    up_data,
  output logic              up_ready,
  output logic              dn_valid,
  output lsc_pkg::out_item_t dn_data,
  input  logic              dn_ready
);
  import lsc_pkg::*;

  logic      c_valid_r, m_valid_r, o_valid_r;
  comb_t     c_r, c_nxt;
  mul_t      m_r, m_nxt;
  out_item_t o_r, o_nxt;
  logic      c_ready, m_ready, o_ready;
  logic      rej;

  function automatic coord_t place(coord_t base, logic neg, prod_t prod);
    logic [PROD_W:0] s;
    mag_t            mag;
    s   = {1'b0, prod} + P_HALF;
    mag = s[PARAM_FRAC_BITS +: COORD_BITS];
    return neg ? coord_t'(base - mag) : coord_t'(base + mag);
  endfunction

  always_comb begin
    c_nxt.seg = up_data.seg;
    c_nxt.u1  = '0;
    c_nxt.u2  = P_ONE;
    rej       = 1'b0;
    for (int i = 0; i < 4; i++) begin
      rej = rej | up_data.e[i].rej;
      if (up_data.e[i].ent && up_data.e[i].quo > c_nxt.u1) begin
        c_nxt.u1 = up_data.e[i].quo;
      end
      if (up_data.e[i].ext && up_data.e[i].quo < c_nxt.u2) begin
        c_nxt.u2 = up_data.e[i].quo;
      end
    end
    c_nxt.ok = !rej && !(c_nxt.u1 > c_nxt.u2);
  end

  always_comb begin
    m_nxt.ok  = c_r.ok;
    m_nxt.seg = c_r.seg;
    m_nxt.px1 = PROD_W'(c_r.u1) * PROD_W'(c_r.seg.adx);
    m_nxt.py1 = PROD_W'(c_r.u1) * PROD_W'(c_r.seg.ady);
    m_nxt.px2 = PROD_W'(c_r.u2) * PROD_W'(c_r.seg.adx);
    m_nxt.py2 = PROD_W'(c_r.u2) * PROD_W'(c_r.seg.ady);
  end

  always_comb begin
    o_nxt = '0;
    if (m_r.ok) begin
      o_nxt.visible         = 1'b1;
      o_nxt.clipped_start_x = place(m_r.seg.sx, m_r.seg.negx, m_r.px1);
      o_nxt.clipped_start_y = place(m_r.seg.sy, m_r.seg.negy, m_r.py1);
      o_nxt.clipped_end_x   = place(m_r.seg.sx, m_r.seg.negx, m_r.px2);
      o_nxt.clipped_end_y   = place(m_r.seg.sy, m_r.seg.negy, m_r.py2);
    end
  end

  assign o_ready  = !o_valid_r || dn_ready;
  assign m_ready  = !m_valid_r || o_ready;
  assign c_ready  = !c_valid_r || m_ready;
  assign up_ready = c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (c_ready) c_valid_r <= up_valid;
      if (m_ready) m_valid_r <= c_valid_r;
      if (o_ready) o_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && up_valid) c_r <= c_nxt;
    if (m_ready && c_valid_r) m_r <= m_nxt;
    if (o_ready && m_valid_r) o_r <= o_nxt;
  end

  assign dn_valid = o_valid_r;
  assign dn_data  = o_r;
endmodule
`default_nettype wire

### sv/line_segment_clipper_unit.sv
// ----------------------------------------------------------------------------
// line_segment_clipper_unit: Liang-Barsky clipper for one segment per transfer
// Window registers, edge setup, a chain of divider cells and the interpolator.
// ----------------------------------------------------------------------------
// The clipper accepts one segment per cycle while in_stall is low and returns one result
// per segment, in order. The pipeline is one setup stage, one restoring-divider cell per
// fraction bit of the entry and exit parameters, then combine, multiply and round
// stages. in_stall rises only when every stage holds a segment and the output transfer
// is stalled.
// Window writes are always taken and must happen while the block is idle.
`default_nettype none
module line_segment_clipper_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lsc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  lsc_pkg::cfg_reg_e  cfg_index,
  input  lsc_pkg::coord_t    cfg_data
);
  import lsc_pkg::*;

  localparam int NCELL = PARAM_FRAC_BITS;

  coord_t win_left_r, win_bottom_r, win_right_r, win_top_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_bottom_r <= '0;
      win_right_r  <= coord_t'(32767);
      win_top_r    <= coord_t'(32767);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT:   win_left_r   <= cfg_data;
        REG_BOTTOM: win_bottom_r <= cfg_data;
        REG_RIGHT:  win_right_r  <= cfg_data;
        REG_TOP:    win_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic edge_t setup(logic signed [DIFF_W-1:0] p,
                                  logic signed [DIFF_W-1:0] q);
    edge_t e;
    logic [DIFF_W-1:0] np, nq;
    e     = '0;
    e.quo = P_ONE;
    np    = DIFF_W'(-p);
    nq    = DIFF_W'(-q);
    if (p == '0) begin
      e.rej = q < 0;
    end else if (p < 0) begin
      if (q < 0) begin
        if (nq > np) begin
          e.rej = 1'b1;
        end else begin
          e.ent = 1'b1;
          e.div = nq < np;
          e.rem = nq[COORD_BITS-1:0];
          e.d   = np[COORD_BITS-1:0];
        end
      end
    end else begin
      if (q < 0) begin
        e.rej = 1'b1;
      end else begin
        e.ext = 1'b1;
        e.div = q < p;
        e.rem = q[COORD_BITS-1:0];
        e.d   = p[COORD_BITS-1:0];
      end
    end
    if (e.div) e.quo = '0;
    return e;
  endfunction

  logic signed [DIFF_W-1:0] sx, sy, dx, dy;
  logic [DIFF_W-1:0] ndx, ndy;
  pipe_t prep_nxt, prep_r;
  logic  prep_valid_r, prep_ready;

  always_comb begin
    sx  = DIFF_W'(in_data.start_x);
    sy  = DIFF_W'(in_data.start_y);
    dx  = DIFF_W'(in_data.end_x) - sx;
    dy  = DIFF_W'(in_data.end_y) - sy;
    ndx = DIFF_W'(-dx);
    ndy = DIFF_W'(-dy);
    prep_nxt.seg.sx   = in_data.start_x;
    prep_nxt.seg.sy   = in_data.start_y;
    prep_nxt.seg.negx = dx < 0;
    prep_nxt.seg.negy = dy < 0;
    prep_nxt.seg.adx  = dx < 0 ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    prep_nxt.seg.ady  = dy < 0 ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    // edge order: left, right, bottom, top
    prep_nxt.e[0] = setup(DIFF_W'(-dx), sx - DIFF_W'(win_left_r));
    prep_nxt.e[1] = setup(dx, DIFF_W'(win_right_r) - sx);
    prep_nxt.e[2] = setup(DIFF_W'(-dy), sy - DIFF_W'(win_bottom_r));
    prep_nxt.e[3] = setup(dy, DIFF_W'(win_top_r) - sy);
  end

  logic  cv [NCELL+1];
  pipe_t cd [NCELL+1];
  logic  cr [NCELL+1];

  assign prep_ready = !prep_valid_r || cr[0];
  assign in_stall   = !prep_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (prep_ready) begin
      prep_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_ready && in_valid) prep_r <= prep_nxt;
  end

  assign cv[0] = prep_valid_r;
  assign cd[0] = prep_r;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    lsc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[k]),
      .up_data  (cd[k]),
      .up_ready (cr[k]),
      .dn_valid (cv[k+1]),
      .dn_data  (cd[k+1]),
      .dn_ready (cr[k+1])
    );
  end

  lsc_lerp u_lerp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cv[NCELL]),
    .up_data  (cd[NCELL]),
    .up_ready (cr[NCELL]),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_ready (!out_stall)
  );
endmodule
`default_nettype wire
